FILE: rtl/smt_pkg.sv
// shared constants and types of the scaled matrix transpose unit
package smt_pkg;

    // default sizes
    localparam int MAX_DIM_DEF    = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed point format of scale and elements
    localparam int FRAC_BITS = 16;
    localparam int SCALE_W   = 32;

    // configuration registers
    localparam int CFG_DIM_W  = 7;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_COLS  = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;

    localparam logic [CFG_DIM_W-1:0]     DIM_RST   = 7'd64;
    localparam logic signed [SCALE_W-1:0] SCALE_RST = 32'sd65536;

    // input commands
    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_DRAIN = 1'b1
    } t_cmd;

endpackage

FILE: rtl/scaled_matrix_transpose_unit.sv
// scaled matrix transpose unit: corner-turn buffer with a q16.16 scale
//
// Input channel (i_in_valid / o_in_stall): each word carries a command and a value.
//   A load word stores one element; elements come column-major for a rows x cols
//   source. Once rows*cols elements are stored, each drain word yields one result
//   word: scale * source(i,j), row-major, with o_last high on the final one, after
//   which the block goes back to loading. Drains before the buffer is full and
//   loads while it is full or draining are dropped.
// Output channel (o_out_valid / i_out_stall): result words from an output register.
// Drain path: a drain word is taken and the element store is read into the read
//   stage, the multiply registers into the multiply stage and the result register
//   loads from it. The input stalls while a drain is in the read or multiply stage:
//   loads go one per cycle, and a drain is not taken until the previous one has
//   left the multiply stage.
// When the receiver stalls, the result word holds; the next drain is still taken
//   and waits in the multiply stage until the output register frees up.
// Configuration (apb): rows at 0x0, cols at 0x4, scale at 0x8, written while idle.
// Reset clears the load count, drain cursor, phase and stage valids and restores the
//   registers; the element store keeps its contents and is not swept.
module scaled_matrix_transpose_unit #(
    parameter int MAX_DIM    = smt_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = smt_pkg::DATA_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_command,
    input  logic signed [DATA_WIDTH-1:0]       i_value,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [DATA_WIDTH-1:0]       o_result,
    output logic                               o_last,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [smt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [smt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [smt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import smt_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int TOT_W  = 2 * DIM_W;
    localparam int PW     = DATA_WIDTH + SCALE_W;   // full product width
    localparam int SH_W   = PW - FRAC_BITS;         // after the fraction shift

    // configuration registers
    logic [CFG_DIM_W-1:0]      r_rows;
    logic [CFG_DIM_W-1:0]      r_cols;
    logic signed [SCALE_W-1:0] r_scale;

    // element store
    logic [DATA_WIDTH-1:0] r_store [DEPTH];

    // control state
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;
    logic             r_draining;

    // read stage and multiply stage
    logic                         r_a_v;
    logic                         r_a_last;
    logic signed [DATA_WIDTH-1:0] r_rd;
    logic                         r_b_v;
    logic                         r_b_last;

    // output register
    logic                         r_out_v;
    logic signed [DATA_WIDTH-1:0] r_result;
    logic                         r_last;

    logic [DIM_W-1:0]             w_rdim;
    logic [DIM_W-1:0]             w_cdim;
    logic [TOT_W-1:0]             w_total;
    logic                         w_full;
    logic                         w_in_fire;
    logic                         w_load_ok;
    logic                         w_drain_ok;
    logic                         w_is_last;
    logic                         w_col_end;
    logic [ADDR_W-1:0]            w_rd_addr;
    logic [ADDR_W-1:0]            w_wr_addr;
    logic                         w_b_fire;
    logic                         w_cfg_wr;
    logic signed [PW-1:0]         w_prod;
    logic signed [SH_W-1:0]       w_sh;
    logic                         w_fits;
    logic signed [DATA_WIDTH-1:0] w_sat;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= DIM_RST;
            r_cols  <= DIM_RST;
            r_scale <= SCALE_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_ROWS:  r_rows  <= pwdata[CFG_DIM_W-1:0];
                REG_COLS:  r_cols  <= pwdata[CFG_DIM_W-1:0];
                REG_SCALE: r_scale <= $signed(pwdata[SCALE_W-1:0]);
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ROWS:  prdata = APB_DATA_W'(r_rows);
            REG_COLS:  prdata = APB_DATA_W'(r_cols);
            REG_SCALE: prdata = APB_DATA_W'(unsigned'(r_scale));
            default:   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // dimensions: zero acts as one, anything above the maximum as the maximum
    // ---------------------------------------------------------------
    always_comb begin
        if (r_rows == '0) begin
            w_rdim = DIM_W'(1);
        end else if (32'(r_rows) > 32'(MAX_DIM)) begin
            w_rdim = DIM_W'(MAX_DIM);
        end else begin
            w_rdim = DIM_W'(r_rows);
        end
        if (r_cols == '0) begin
            w_cdim = DIM_W'(1);
        end else if (32'(r_cols) > 32'(MAX_DIM)) begin
            w_cdim = DIM_W'(MAX_DIM);
        end else begin
            w_cdim = DIM_W'(r_cols);
        end
    end

    assign w_total = TOT_W'(w_rdim) * TOT_W'(w_cdim);
    assign w_full  = 32'(r_count) >= 32'(w_total);

    // ---------------------------------------------------------------
    // input side: one drain in the read/multiply stages at a time
    // ---------------------------------------------------------------
    assign o_in_stall = r_a_v || r_b_v;
    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_load_ok  = w_in_fire && (i_command == CMD_LOAD) && !r_draining && !w_full;
    assign w_drain_ok = w_in_fire && (i_command == CMD_DRAIN) && (r_draining || w_full);

    // drain cursor; it sits at (0,0) whenever no drain is under way
    assign w_col_end = DIM_W'(r_col) >= (w_cdim - DIM_W'(1));
    assign w_is_last = (DIM_W'(r_row) >= (w_rdim - DIM_W'(1))) && w_col_end;

    // column-major store: element (i,j) sits at i + j*rows
    assign w_rd_addr = ADDR_W'(r_row) + ADDR_W'(r_col) * ADDR_W'(w_rdim);
    assign w_wr_addr = r_count[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_draining <= 1'b0;
        end else if (w_load_ok) begin
            r_count <= r_count + CNT_W'(1);
        end else if (w_drain_ok) begin
            if (w_is_last) begin
                r_draining <= 1'b0;
                r_count    <= '0;
                r_row      <= '0;
                r_col      <= '0;
            end else begin
                r_draining <= 1'b1;
                if (w_col_end) begin
                    r_col <= '0;
                    r_row <= r_row + IDX_W'(1);
                end else begin
                    r_col <= r_col + IDX_W'(1);
                end
            end
        end
    end

    // store write on load, registered read on drain
    always_ff @(posedge i_clk) begin
        if (w_load_ok) begin
            r_store[w_wr_addr] <= i_value;
        end
        if (w_drain_ok) begin
            r_rd <= $signed(r_store[w_rd_addr]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_drain_ok) begin
            r_a_last <= w_is_last;
        end
        if (r_a_v) begin
            r_b_last <= r_a_last;
        end
    end

    // ---------------------------------------------------------------
    // multiply stage
    // ---------------------------------------------------------------
    generate
        if (DATA_WIDTH <= 32) begin : g_mul_one
            logic signed [PW-1:0] r_prod;

            always_ff @(posedge i_clk) begin
                if (r_a_v) begin
                    r_prod <= r_rd * r_scale;
                end
            end

            assign w_prod = r_prod;
        end else begin : g_mul_two
            // split the element so that the low multiplier stays within 33 x 32
            logic signed [SCALE_W+32:0]   r_plo;
            logic signed [DATA_WIDTH-1:0] r_phi;

            always_ff @(posedge i_clk) begin
                if (r_a_v) begin
                    r_plo <= $signed({1'b0, r_rd[31:0]}) * r_scale;
                    r_phi <= $signed(r_rd[DATA_WIDTH-1:32]) * r_scale;
                end
            end

            assign w_prod = (PW'(r_phi) <<< 32) + PW'(r_plo);
        end
    endgenerate

    // arithmetic shift by the fraction bits, then saturate
    assign w_sh   = $signed(w_prod[PW-1:FRAC_BITS]);
    assign w_fits = (w_sh[SH_W-1:DATA_WIDTH-1] == '0) || (w_sh[SH_W-1:DATA_WIDTH-1] == '1);

    always_comb begin
        if (w_fits) begin
            w_sat = w_sh[DATA_WIDTH-1:0];
        end else if (w_sh[SH_W-1]) begin
            w_sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    // ---------------------------------------------------------------
    // stage valids and output register
    // ---------------------------------------------------------------
    assign w_b_fire = r_b_v && (!r_out_v || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_a_v <= w_drain_ok;
            if (r_a_v) begin
                r_b_v <= 1'b1;
            end else if (w_b_fire) begin
                r_b_v <= 1'b0;
            end
            if (w_b_fire) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_fire) begin
            r_result <= w_sat;
            r_last   <= r_b_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_result    = r_result;
    assign o_last      = r_last;

endmodule

FILE: tb/testbench.sv
// testbench for the scaled matrix transpose unit: directed corners, register limits and random matrices
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smt_pkg::*;

    localparam int  STORE_DEPTH   = MAX_DIM_DEF * MAX_DIM_DEF;
    // margin for a drain word to pass the read and multiply stages into the output register
    localparam int  SETTLE_CYCLES = 4;
    localparam int  CYCLE_LIMIT   = 1_000_000;
    localparam int  RANDOM_WORDS  = 100;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam longint      SAT_HI = 64'sd2147483647;
    localparam longint      SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] result;
        logic               last;
    } t_result_word;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    // input channel
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_command  = 1'b0;
    logic [31:0] i_value    = '0;
    // output channel
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_result;
    logic        o_last;
    // configuration port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    scaled_matrix_transpose_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_result),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // shadow of the block: registers, corner-turn buffer and drain cursor
    logic [CFG_DIM_W-1:0] reg_rows  = DIM_RST;
    logic [CFG_DIM_W-1:0] reg_cols  = DIM_RST;
    logic signed [31:0]   reg_scale = SCALE_RST;
    logic signed [31:0]   stored_elem [STORE_DEPTH];
    int                   fill_count = 0;
    int                   out_row    = 0;
    int                   out_col    = 0;
    bit                   unloading  = 1'b0;

    // result words still owed by the block, oldest first
    t_result_word pending_results [$];

    // idling switches, redrawn per phase
    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;

    int mismatches      = 0;
    int words_sent      = 0;
    int useful_words    = 0;
    int results_checked = 0;
    int matrices_done   = 0;
    int cycle_count     = 0;
    int out_hold        = 0;
    t_result_word want;

    // out-of-range dimensions are pinned to 1 and to the maximum dimension
    function automatic int effective_dim(logic [CFG_DIM_W-1:0] d);
        if (d == 0) return 1;
        if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(d);
    endfunction

    function automatic int matrix_size();
        return effective_dim(reg_rows) * effective_dim(reg_cols);
    endfunction

    // q16.16 product, floor shift, saturated to 32 bits
    function automatic logic signed [31:0] scale_q16(logic signed [31:0] elem,
                                                     logic signed [31:0] sc);
        longint prod;
        prod = (longint'(elem) * longint'(sc)) >>> FRAC_BITS;
        if (prod > SAT_HI) return Q_MAX;
        if (prod < SAT_LO) return Q_MIN;
        return prod[31:0];
    endfunction

    // advance the shadow by one accepted word, queueing the result it owes
    function automatic void turn_word(t_cmd cmd, logic signed [31:0] val);
        int r;
        int c;
        int addr;
        t_result_word w;
        r = effective_dim(reg_rows);
        c = effective_dim(reg_cols);
        if (cmd == CMD_LOAD) begin
            // loads while full or while draining are dropped
            if (!unloading && fill_count < r * c) begin
                stored_elem[fill_count % STORE_DEPTH] = val;
                fill_count++;
                useful_words++;
            end
            return;
        end
        if (!unloading) begin
            // drain before the buffer is full is dropped
            if (fill_count < r * c) return;
            unloading = 1'b1;
            out_row   = 0;
            out_col   = 0;
        end
        addr     = (out_row + out_col * r) % STORE_DEPTH;
        w.result = scale_q16(stored_elem[addr], reg_scale);
        w.last   = (out_row >= r - 1) && (out_col >= c - 1);
        pending_results.push_back(w);
        useful_words++;
        if (w.last) begin
            unloading  = 1'b0;
            fill_count = 0;
            out_row    = 0;
            out_col    = 0;
            matrices_done++;
        end else if (out_col >= c - 1) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endfunction

    function automatic logic [31:0] pick_element();
        logic signed [31:0] frac;
        frac = $urandom_range(1, 196608);
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return frac;
            3:       return -frac;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        logic signed [31:0] frac;
        frac = $urandom_range(0, 262144);
        case ($urandom_range(0, 7))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return '0;
            3:       return Q_ONE;
            4:       return frac;
            5:       return -frac;
            default: return $urandom;
        endcase
    endfunction

    // one word on the input channel; valid stays up after the accept
    task automatic send_word(input t_cmd cmd, input logic [31:0] val);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
        turn_word(cmd, val);
    endtask

    // hold off input until every owed result is out and the pipe is empty
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup then access cycle; the register takes the data at the access edge
    task automatic apb_write(input logic [1:0] index, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_ROWS:  reg_rows  = data[CFG_DIM_W-1:0];
            REG_COLS:  reg_cols  = data[CFG_DIM_W-1:0];
            REG_SCALE: reg_scale = data;
            default:   ;
        endcase
        // back to idle between transfers
        @(posedge i_clk);
    endtask

    task automatic set_matrix(input int r, input int c, input logic [31:0] sc);
        quiesce();
        apb_write(REG_ROWS, 32'(r));
        apb_write(REG_COLS, 32'(c));
        apb_write(REG_SCALE, sc);
    endtask

    // fill the buffer; when shaking, mix in early drains and resizes
    task automatic load_until_full(input bit shake);
        while (fill_count < matrix_size()) begin
            if (shake && $urandom_range(0, 11) == 0) send_word(CMD_DRAIN, $urandom);
            if (shake && fill_count > 0 && $urandom_range(0, 39) == 0) begin
                quiesce();
                if ($urandom_range(0, 1) == 1) apb_write(REG_ROWS, $urandom_range(0, 8));
                else apb_write(REG_COLS, $urandom_range(0, 8));
            end
            send_word(CMD_LOAD, pick_element());
        end
    endtask

    // empty the buffer; when shaking, mix in dropped loads and shrink mid-drain
    task automatic drain_until_last(input bit shake);
        do begin
            if (shake && $urandom_range(0, 11) == 0) send_word(CMD_LOAD, pick_element());
            if (shake && unloading && $urandom_range(0, 29) == 0) begin
                // shrinking only, so every read stays inside the loaded region
                quiesce();
                if ($urandom_range(0, 1) == 1)
                    apb_write(REG_ROWS, $urandom_range(0, effective_dim(reg_rows)));
                else
                    apb_write(REG_COLS, $urandom_range(0, effective_dim(reg_cols)));
            end
            send_word(CMD_DRAIN, $urandom);
        end while (unloading);
    endtask

    // reset values: a drain after 64 loads is dropped, then a 64 x 1 matrix
    task automatic test_reset_defaults();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (64) send_word(CMD_LOAD, pick_element());
        send_word(CMD_DRAIN, '0);            // buffer far from full, dropped
        quiesce();
        apb_write(REG_COLS, 32'd1);
        drain_until_last(1'b0);
    endtask

    // saturation both ways, floor rounding, dropped drains and dropped loads
    task automatic test_corner_values();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        set_matrix(2, 2, Q_MIN);
        send_word(CMD_DRAIN, '0);            // empty buffer, dropped
        send_word(CMD_LOAD, Q_MAX);
        send_word(CMD_LOAD, Q_MIN);
        send_word(CMD_LOAD, '0);
        send_word(CMD_LOAD, 32'hFFFF_FFFF);
        send_word(CMD_LOAD, 32'h1234_5678);  // buffer full, dropped
        send_word(CMD_DRAIN, '0);            // max * min saturates low
        send_word(CMD_LOAD, 32'h0BAD_F00D);  // drain running, dropped
        send_word(CMD_DRAIN, 32'hFFFF_FFFF);
        send_word(CMD_DRAIN, '0);            // min * min saturates high
        send_word(CMD_DRAIN, '0);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        set_matrix(1, 2, Q_MAX);
        send_word(CMD_LOAD, 32'hFFFF_FFFF);  // negative product rounds down
        send_word(CMD_LOAD, Q_ONE);
        send_word(CMD_DRAIN, '0);
        send_word(CMD_DRAIN, '0);
    endtask

    // register extremes, including out-of-range dimensions
    task automatic test_dim_limits();
        int r;
        int c;
        logic [31:0] sc;
        for (int k = 0; k < 6; k++) begin
            case (k)
                0:       begin r = 0;   c = 0;   sc = Q_MIN;         end
                1:       begin r = 127; c = 1;   sc = Q_MAX;         end
                2:       begin r = 1;   c = 127; sc = '0;            end
                3:       begin r = 1;   c = 1;   sc = 32'hFFFF_0000; end
                4:       begin r = 3;   c = 5;   sc = 32'h0000_8000; end
                default: begin r = 6;   c = 2;   sc = Q_ONE;         end
            endcase
            tx_idle = k[0];
            rx_idle = k[1];
            set_matrix(r, c, sc);
            load_until_full(1'b0);
            drain_until_last(1'b0);
        end
    endtask

    // dimensions rewritten while a matrix is half loaded or half drained
    task automatic test_mid_matrix_resize();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        set_matrix(4, 4, 32'h0000_8000);
        repeat (5) send_word(CMD_LOAD, pick_element());
        quiesce();
        apb_write(REG_ROWS, 32'd2);          // shrinks, but stays past the loaded count
        load_until_full(1'b0);
        repeat (3) send_word(CMD_DRAIN, '0);
        quiesce();
        apb_write(REG_COLS, 32'd2);          // cursor already past the new width
        drain_until_last(1'b0);
        set_matrix(3, 3, pick_scale());
        repeat (6) send_word(CMD_LOAD, pick_element());
        quiesce();
        apb_write(REG_ROWS, 32'd1);          // now smaller than what is loaded
        send_word(CMD_LOAD, pick_element());
        drain_until_last(1'b0);
    endtask

    // random small matrices with noise and resizing mixed in
    task automatic test_random_matrices();
        int r;
        int c;
        int start;
        start = useful_words;
        while (useful_words - start < RANDOM_WORDS) begin
            r = $urandom_range(1, 6);
            c = $urandom_range(1, 6);
            case ($urandom_range(0, 31))
                0:       r = 0;
                1:       c = 0;
                2:       begin r = $urandom_range(65, 127); c = $urandom_range(0, 1); end
                3:       begin c = $urandom_range(65, 127); r = $urandom_range(0, 1); end
                default: ;
            endcase
            quiesce();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0) apb_write(REG_ROWS, 32'(r));
            if ($urandom_range(0, 3) != 0) apb_write(REG_COLS, 32'(c));
            if ($urandom_range(0, 3) != 0) apb_write(REG_SCALE, pick_scale());
            load_until_full(1'b1);
            drain_until_last(1'b1);
        end
    endtask

    // receiver: checks each result word and stalls at random after it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_hold = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result word with nothing owed: result %0d last %0b",
                           $signed(o_result), o_last);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_result !== want.result) begin
                        $error("result: expected %0d, got %0d",
                               $signed(want.result), $signed(o_result));
                        mismatches++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_last);
                        mismatches++;
                    end
                    results_checked++;
                end
                out_hold = rx_idle ? $urandom_range(0, 7) : 0;
            end else if (out_hold > 0) begin
                out_hold--;
            end
            i_out_stall <= (out_hold != 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results owed",
                     cycle_count, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_corner_values();
        test_dim_limits();
        test_mid_matrix_resize();
        test_random_matrices();
        quiesce();
        $display("%0d input words taken (%0d took effect), %0d result words checked",
                 words_sent, useful_words, results_checked);
        $display("%0d matrices drained: reset values, clamped sizes, resizes, saturation",
                 matrices_done);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
